// File: src/tile_animation_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Tile animation sequencer assertion macros
// Property wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef TILE_ANIMATION_SEQUENCER_ASSERT_SVH
`define TILE_ANIMATION_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define TAS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TAS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/tas_pkg.sv
// ----------------------------------------------------------------------------
// Tile animation sequencer package
// Shared constants, codes, types and the LFSR step function.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int NUM_TILES = 1024;
    localparam int NUM_SLOTS = 128;
    localparam int TILE_W    = 10;
    localparam int SLOT_W    = 7;
    localparam int DELAY_W   = 16;
    localparam int LFSR_W    = 16;
    localparam int SPAN_W    = TILE_W + 1;

    localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;
    localparam logic [DELAY_W-1:0] CNT_MAX   = 16'hFFFF;

    localparam logic [1:0] REQ_TICK        = 2'd0;
    localparam logic [1:0] REQ_WRITE_SLOT  = 2'd1;
    localparam logic [1:0] REQ_WRITE_REMAP = 2'd2;
    localparam logic [1:0] REQ_LOOKUP      = 2'd3;

    localparam logic [1:0] MODE_FORWARD  = 2'd0;
    localparam logic [1:0] MODE_BACKWARD = 2'd1;
    localparam logic [1:0] MODE_RANDOM   = 2'd2;
    localparam logic [1:0] MODE_PINGPONG = 2'd3;

    typedef struct packed {
        logic [TILE_W-1:0]  start;
        logic [TILE_W-1:0]  finish;
        logic [DELAY_W-1:0] delay;
        logic [1:0]         mode;
    } slot_t;

    typedef struct packed {
        logic               start;
        logic [LFSR_W-1:0]  dividend;
        logic [SPAN_W-1:0]  divisor;
    } div_req_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// File: src/tas_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/tas_divider.sv
// ----------------------------------------------------------------------------
// Tile animation sequencer remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tas_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tas_pkg::div_req_t            req,
    output logic                         done,
    output logic [tas_pkg::TILE_W-1:0]   rem
);

    logic [tas_pkg::LFSR_W-1:0] dvd_reg;
    logic [tas_pkg::SPAN_W-1:0] dvs_reg;
    logic [tas_pkg::SPAN_W-1:0] rem_reg;
    logic [3:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [tas_pkg::SPAN_W:0]   shifted;
    logic [tas_pkg::SPAN_W:0]   diff;

    assign shifted = {rem_reg, dvd_reg[tas_pkg::LFSR_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= 4'd15;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= dvd_reg << 1;
                if (shifted >= {1'b0, dvs_reg}) begin
                    rem_reg <= diff[tas_pkg::SPAN_W-1:0];
                end else begin
                    rem_reg <= shifted[tas_pkg::SPAN_W-1:0];
                end
                cnt_reg  <= cnt_reg - 4'd1;
                busy_reg <= (cnt_reg != 4'd0);
                done_reg <= (cnt_reg == 4'd0);
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[tas_pkg::TILE_W-1:0];

endmodule

// File: src/tile_animation_sequencer.sv
// Result: a write goes to ST_DONE, a lookup via ST_LOOK; ST_DONE waits for a free output register.
// Throughput: one item at a time; s_ready returns with the result word.
// Tick: each slot passes ST_SLOT_RD and ST_SLOT_EV; each tile of a fired slot passes ST_ENT_RD
// and ST_ENT_UPD, and in random mode also ST_ENT_DIV to wait for the one-bit-a-cycle remainder unit.
// Reset: synchronous, active low; a clearing pass over the flag, slot and counter
// memories follows, with s_ready low.
// ----------------------------------------------------------------------------
// Tile animation sequencer
// Remap table with animation slots stepped by a sequencer on each tick.
// ----------------------------------------------------------------------------
`include "tile_animation_sequencer_assert.svh"

module tile_animation_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [tas_pkg::SLOT_W-1:0]    s_slot,
    input  logic [tas_pkg::TILE_W-1:0]    s_anim_start,
    input  logic [tas_pkg::TILE_W-1:0]    s_anim_finish,
    input  logic [tas_pkg::DELAY_W-1:0]   s_anim_delay,
    input  logic [1:0]                    s_anim_mode,
    input  logic [tas_pkg::TILE_W-1:0]    s_tile,
    input  logic [tas_pkg::TILE_W-1:0]    s_tile_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tas_pkg::TILE_W-1:0]    m_mapped_tile,
    output logic                          m_bounce_dir
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_LOOK    = 4'd2;
    localparam logic [3:0] ST_SLOT_RD = 4'd3;
    localparam logic [3:0] ST_SLOT_EV = 4'd4;
    localparam logic [3:0] ST_ENT_RD  = 4'd5;
    localparam logic [3:0] ST_ENT_UPD = 4'd6;
    localparam logic [3:0] ST_ENT_DIV = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [tas_pkg::SLOT_W-1:0] LAST_SLOT = tas_pkg::SLOT_W'(tas_pkg::NUM_SLOTS - 1);
    localparam logic [tas_pkg::TILE_W-1:0] LAST_TILE = tas_pkg::TILE_W'(tas_pkg::NUM_TILES - 1);

    logic [3:0]                  state_reg, state_next;
    logic [tas_pkg::TILE_W-1:0]  clr_reg;
    logic [tas_pkg::SLOT_W-1:0]  sidx_reg;
    logic [tas_pkg::TILE_W-1:0]  t_reg;
    logic [tas_pkg::LFSR_W-1:0]  lfsr_reg;
    logic [tas_pkg::TILE_W-1:0]  res_map_reg;
    logic                        res_dir_reg;
    logic                        m_valid_reg;
    logic [tas_pkg::TILE_W-1:0]  m_map_reg;
    logic                        m_dir_reg;

    logic                        accept;
    logic                        clearing;
    logic                        out_free;
    tas_pkg::slot_t              slot_rd;
    tas_pkg::slot_t              slot_wr;
    logic [tas_pkg::DELAY_W-1:0] cnt_rd, cnt_wr;
    logic [tas_pkg::TILE_W-1:0]  remap_rd;
    logic                        flag_rd;
    logic                        fire;
    logic                        ent_wr;
    logic                        flag_wr;
    logic [tas_pkg::TILE_W-1:0]  new_v;
    logic                        new_flag;
    logic [tas_pkg::SPAN_W-1:0]  span;
    logic [tas_pkg::LFSR_W-1:0]  lfsr_nx;
    tas_pkg::div_req_t           div_req;
    logic                        div_done;
    logic [tas_pkg::TILE_W-1:0]  div_rem;

    logic                        remap_we;
    logic [tas_pkg::TILE_W-1:0]  remap_addr, remap_wdata, remap_raddr;
    logic                        flag_we;
    logic [tas_pkg::TILE_W-1:0]  flag_addr;
    logic                        slot_we;
    logic [tas_pkg::SLOT_W-1:0]  slot_addr;
    logic                        cnt_we;
    logic [tas_pkg::SLOT_W-1:0]  cnt_addr;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign clearing = (state_reg == ST_CLEAR);
    assign out_free = !m_valid_reg || m_ready;
    assign span     = {1'b0, slot_rd.finish} - {1'b0, slot_rd.start} + tas_pkg::SPAN_W'(1);
    assign lfsr_nx  = tas_pkg::lfsr_step(lfsr_reg);
    assign fire     = (slot_rd.delay != '0) && (slot_rd.delay < cnt_rd);

    // entry update
    always_comb begin
        new_v    = remap_rd;
        new_flag = flag_rd;
        case (slot_rd.mode)
            tas_pkg::MODE_FORWARD:
                new_v = (remap_rd < slot_rd.finish) ? remap_rd + 1'b1 : slot_rd.start;
            tas_pkg::MODE_BACKWARD:
                new_v = (remap_rd > slot_rd.start) ? remap_rd - 1'b1 : slot_rd.finish;
            tas_pkg::MODE_RANDOM:
                new_v = slot_rd.start + div_rem;
            default: begin
                if (flag_rd) begin
                    if (remap_rd != slot_rd.start) begin
                        new_v = remap_rd - 1'b1;
                    end else begin
                        new_v    = remap_rd + 1'b1;
                        new_flag = 1'b0;
                    end
                end else begin
                    if (remap_rd != slot_rd.finish) begin
                        new_v = remap_rd + 1'b1;
                    end else begin
                        new_v    = remap_rd - 1'b1;
                        new_flag = 1'b1;
                    end
                end
            end
        endcase
    end

    assign ent_wr  = ((state_reg == ST_ENT_UPD) && (slot_rd.mode != tas_pkg::MODE_RANDOM))
                     || ((state_reg == ST_ENT_DIV) && div_done);
    assign flag_wr = (state_reg == ST_ENT_UPD) && (slot_rd.mode == tas_pkg::MODE_PINGPONG);

    assign div_req.start    = (state_reg == ST_ENT_UPD) && (slot_rd.mode == tas_pkg::MODE_RANDOM);
    assign div_req.dividend = lfsr_nx;
    assign div_req.divisor  = span;

    assign cnt_wr = fire ? tas_pkg::DELAY_W'(1)
                  : ((cnt_rd < tas_pkg::CNT_MAX) ? cnt_rd + 1'b1 : cnt_rd);

    assign slot_wr.start  = s_anim_start;
    assign slot_wr.finish = s_anim_finish;
    assign slot_wr.delay  = s_anim_delay;
    assign slot_wr.mode   = s_anim_mode;

    assign remap_we    = (accept && (s_req_type == tas_pkg::REQ_WRITE_REMAP)) || ent_wr;
    assign remap_addr  = (state_reg == ST_IDLE) ? s_tile : t_reg;
    assign remap_wdata = (state_reg == ST_IDLE) ? s_tile_value : new_v;
    assign remap_raddr = (state_reg == ST_IDLE) ? s_tile : t_reg;
    assign flag_we     = clearing || flag_wr;
    assign flag_addr   = clearing ? clr_reg : t_reg;
    assign slot_we     = clearing || (accept && (s_req_type == tas_pkg::REQ_WRITE_SLOT));
    assign slot_addr   = clearing ? clr_reg[tas_pkg::SLOT_W-1:0] : s_slot;
    assign cnt_we      = clearing || (state_reg == ST_SLOT_EV);
    assign cnt_addr    = clearing ? clr_reg[tas_pkg::SLOT_W-1:0] : sidx_reg;

    tas_ram #(.WIDTH(tas_pkg::TILE_W), .DEPTH(tas_pkg::NUM_TILES)) u_remap (
        .aclk(aclk), .wr_en(remap_we), .wr_addr(remap_addr), .wr_data(remap_wdata),
        .rd_addr(remap_raddr), .rd_data(remap_rd)
    );

    tas_ram #(.WIDTH(1), .DEPTH(tas_pkg::NUM_TILES)) u_flags (
        .aclk(aclk), .wr_en(flag_we), .wr_addr(flag_addr), .wr_data(clearing ? 1'b0 : new_flag),
        .rd_addr(remap_raddr), .rd_data(flag_rd)
    );

    tas_ram #(.WIDTH($bits(tas_pkg::slot_t)), .DEPTH(tas_pkg::NUM_SLOTS)) u_slots (
        .aclk(aclk), .wr_en(slot_we), .wr_addr(slot_addr),
        .wr_data(clearing ? '0 : slot_wr), .rd_addr(sidx_reg), .rd_data(slot_rd)
    );

    tas_ram #(.WIDTH(tas_pkg::DELAY_W), .DEPTH(tas_pkg::NUM_SLOTS)) u_counters (
        .aclk(aclk), .wr_en(cnt_we), .wr_addr(cnt_addr),
        .wr_data(clearing ? '0 : cnt_wr), .rd_addr(sidx_reg), .rd_data(cnt_rd)
    );

    tas_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .done(div_done), .rem(div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == LAST_TILE) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req_type)
                        tas_pkg::REQ_TICK:   state_next = ST_SLOT_RD;
                        tas_pkg::REQ_LOOKUP: state_next = ST_LOOK;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOOK:    state_next = ST_DONE;
            ST_SLOT_RD: state_next = ST_SLOT_EV;
            ST_SLOT_EV: begin
                if (fire && (slot_rd.start <= slot_rd.finish)) begin
                    state_next = ST_ENT_RD;
                end else begin
                    state_next = (sidx_reg == LAST_SLOT) ? ST_DONE : ST_SLOT_RD;
                end
            end
            ST_ENT_RD:  state_next = ST_ENT_UPD;
            ST_ENT_UPD, ST_ENT_DIV: begin
                if (ent_wr) begin
                    if (t_reg != slot_rd.finish) begin
                        state_next = ST_ENT_RD;
                    end else begin
                        state_next = (sidx_reg == LAST_SLOT) ? ST_DONE : ST_SLOT_RD;
                    end
                end else if (state_reg == ST_ENT_UPD) begin
                    state_next = ST_ENT_DIV;
                end
            end
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            sidx_reg    <= '0;
            lfsr_reg    <= tas_pkg::LFSR_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept) begin
                sidx_reg    <= '0;
                res_map_reg <= '0;
                res_dir_reg <= 1'b0;
            end
            if (state_reg == ST_LOOK) begin
                res_map_reg <= remap_rd;
                res_dir_reg <= flag_rd;
            end
            if ((state_reg == ST_SLOT_EV) && (state_next == ST_ENT_RD)) begin
                t_reg <= slot_rd.start;
            end
            if (ent_wr && (state_next == ST_ENT_RD)) begin
                t_reg <= t_reg + 1'b1;
            end
            if (state_next == ST_SLOT_RD && state_reg != ST_IDLE) begin
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (div_req.start) begin
                lfsr_reg <= lfsr_nx;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
                m_map_reg   <= res_map_reg;
                m_dir_reg   <= res_dir_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mapped_tile = m_map_reg;
    assign m_bounce_dir  = m_dir_reg;

    `TAS_ASSERT_NOW(a_ent_in_range, aclk, aresetn, state_reg == ST_ENT_UPD, (t_reg >= slot_rd.start) && (t_reg <= slot_rd.finish))
    `TAS_ASSERT_NOW(a_rem_below_span, aclk, aresetn, div_done, {1'b0, div_rem} < span)
    `TAS_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg && $stable(m_map_reg))
    `TAS_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready)

endmodule

// File: verif/tb_tile_animation_sequencer.sv
// ----------------------------------------------------------------------------
// Tile animation sequencer testbench
// Drives slot, remap, lookup and tick words with random gaps on both sides,
// predicts every result word from a local copy of the tables and checks each
// one in order.
// ----------------------------------------------------------------------------
module tb_tile_animation_sequencer;

    typedef struct {
        logic [1:0]                  req;
        logic [tas_pkg::SLOT_W-1:0]  slot;
        logic [tas_pkg::TILE_W-1:0]  start;
        logic [tas_pkg::TILE_W-1:0]  finish;
        logic [tas_pkg::DELAY_W-1:0] delay;
        logic [1:0]                  mode;
        logic [tas_pkg::TILE_W-1:0]  tile;
        logic [tas_pkg::TILE_W-1:0]  value;
    } word_t;

    class remap_scoreboard;
        logic [tas_pkg::TILE_W-1:0]  remap [tas_pkg::NUM_TILES];
        bit                          flags [tas_pkg::NUM_TILES];
        tas_pkg::slot_t              slots [tas_pkg::NUM_SLOTS];
        int unsigned                 counters [tas_pkg::NUM_SLOTS];
        logic [tas_pkg::LFSR_W-1:0]  lfsr;
        logic [tas_pkg::TILE_W:0]    lookups_due [$];
        int                          errors;
        int                          checked;
        int                          fired;

        function new();
            for (int t = 0; t < tas_pkg::NUM_TILES; t++) begin
                remap[t] = '0;
                flags[t] = 0;
            end
            for (int i = 0; i < tas_pkg::NUM_SLOTS; i++) begin
                slots[i] = '0;
                counters[i] = 0;
            end
            lfsr = tas_pkg::LFSR_SEED;
        endfunction

        function void advance_tile(tas_pkg::slot_t s, int t);
            int v;
            int span;
            v = remap[t];
            case (s.mode)
                tas_pkg::MODE_FORWARD: v = (v < s.finish) ? v + 1 : s.start;
                tas_pkg::MODE_BACKWARD: v = (v > s.start) ? v - 1 : s.finish;
                tas_pkg::MODE_RANDOM: begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ tas_pkg::LFSR_TAPS) : (lfsr >> 1);
                    span = s.finish - s.start + 1;
                    v = s.start + (lfsr % span);
                end
                default: begin
                    if (flags[t]) begin
                        if (v != s.start) v = v - 1;
                        else begin v = v + 1; flags[t] = 0; end
                    end else begin
                        if (v != s.finish) v = v + 1;
                        else begin v = v - 1; flags[t] = 1; end
                    end
                end
            endcase
            remap[t] = v[tas_pkg::TILE_W-1:0];
        endfunction

        function void note(word_t w);
            logic [tas_pkg::TILE_W-1:0] mapped;
            bit dir;
            mapped = '0;
            dir = 0;
            case (w.req)
                tas_pkg::REQ_TICK: begin
                    for (int i = 0; i < tas_pkg::NUM_SLOTS; i++) begin
                        if (slots[i].delay != 0 && slots[i].delay < counters[i]) begin
                            counters[i] = 0;
                            fired++;
                            if (slots[i].start <= slots[i].finish)
                                for (int t = slots[i].start; t <= slots[i].finish; t++)
                                    advance_tile(slots[i], t);
                        end
                        if (counters[i] < tas_pkg::CNT_MAX) counters[i]++;
                    end
                end
                tas_pkg::REQ_WRITE_SLOT: slots[w.slot] = '{w.start, w.finish, w.delay, w.mode};
                tas_pkg::REQ_WRITE_REMAP: remap[w.tile] = w.value;
                default: begin
                    mapped = remap[w.tile];
                    dir = flags[w.tile];
                end
            endcase
            lookups_due.push_back({dir, mapped});
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check(logic [tas_pkg::TILE_W-1:0] mapped, logic dir);
            logic [tas_pkg::TILE_W:0] due;
            checked++;
            if (lookups_due.size() == 0) begin
                report($sformatf("unexpected word mapped=%0d dir=%0d", mapped, dir));
            end else begin
                due = lookups_due.pop_front();
                if (mapped !== due[tas_pkg::TILE_W-1:0])
                    report($sformatf("word %0d mapped_tile %0d, want %0d",
                                     checked, mapped, due[tas_pkg::TILE_W-1:0]));
                if (dir !== due[tas_pkg::TILE_W])
                    report($sformatf("word %0d bounce_dir %0d, want %0d",
                                     checked, dir, due[tas_pkg::TILE_W]));
            end
        endtask
    endclass

    logic                         aclk = 0;
    logic                         aresetn = 0;
    logic                         s_valid = 0;
    logic                         s_ready;
    logic [1:0]                   s_req_type = '0;
    logic [tas_pkg::SLOT_W-1:0]   s_slot = '0;
    logic [tas_pkg::TILE_W-1:0]   s_anim_start = '0;
    logic [tas_pkg::TILE_W-1:0]   s_anim_finish = '0;
    logic [tas_pkg::DELAY_W-1:0]  s_anim_delay = '0;
    logic [1:0]                   s_anim_mode = '0;
    logic [tas_pkg::TILE_W-1:0]   s_tile = '0;
    logic [tas_pkg::TILE_W-1:0]   s_tile_value = '0;
    logic                         m_valid;
    logic                         m_ready = 0;
    logic [tas_pkg::TILE_W-1:0]   m_mapped_tile;
    logic                         m_bounce_dir;

    remap_scoreboard sb = new();
    bit      written [tas_pkg::NUM_TILES];
    int      written_list [$];
    bit      quiet = 0;
    bit      hold_rx = 0;
    int      sent = 0;
    int      idle_cycles = 0;
    int      ticks = 0;

    always #1 aclk = ~aclk;

    tile_animation_sequencer dut (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 1000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : receiver
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        @(posedge aclk);
        m_ready <= 1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check(m_mapped_tile, m_bounce_dir);
            if (hold_rx) begin
                hold_rx = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    function word_t noise_word();
        word_t w;
        w.req = tas_pkg::REQ_TICK;
        w.slot = tas_pkg::SLOT_W'($urandom);
        w.start = tas_pkg::TILE_W'($urandom);
        w.finish = tas_pkg::TILE_W'($urandom);
        w.delay = tas_pkg::DELAY_W'($urandom);
        w.mode = 2'($urandom);
        w.tile = tas_pkg::TILE_W'($urandom);
        w.value = tas_pkg::TILE_W'($urandom);
        return w;
    endfunction

    task send(word_t w);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1;
        s_req_type <= w.req;
        s_slot <= w.slot;
        s_anim_start <= w.start;
        s_anim_finish <= w.finish;
        s_anim_delay <= w.delay;
        s_anim_mode <= w.mode;
        s_tile <= w.tile;
        s_tile_value <= w.value;
        do @(posedge aclk); while (!s_ready);
        sb.note(w);
        sent++;
        if (w.req == tas_pkg::REQ_TICK) ticks++;
        if (w.req == tas_pkg::REQ_WRITE_REMAP && !written[w.tile]) begin
            written[w.tile] = 1;
            written_list.push_back(w.tile);
        end
    endtask

    task write_remap(int t, int v);
        word_t w;
        w = noise_word();
        w.req = tas_pkg::REQ_WRITE_REMAP;
        w.tile = tas_pkg::TILE_W'(t);
        w.value = tas_pkg::TILE_W'(v);
        send(w);
    endtask

    task lookup(int t);
        word_t w;
        w = noise_word();
        w.req = tas_pkg::REQ_LOOKUP;
        w.tile = tas_pkg::TILE_W'(t);
        send(w);
    endtask

    task tick();
        word_t w;
        w = noise_word();
        w.req = tas_pkg::REQ_TICK;
        send(w);
    endtask

    task write_slot(int s, int a, int b, int d, logic [1:0] m);
        word_t w;
        w = noise_word();
        if (d != 0)
            for (int t = a; t <= b; t++)
                if (!written[t]) write_remap(t, $urandom);
        w.req = tas_pkg::REQ_WRITE_SLOT;
        w.slot = tas_pkg::SLOT_W'(s);
        w.start = tas_pkg::TILE_W'(a);
        w.finish = tas_pkg::TILE_W'(b);
        w.delay = tas_pkg::DELAY_W'(d);
        w.mode = m;
        send(w);
    endtask

    task random_word();
        int pick;
        int a;
        int b;
        int d;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            tick();
        end else if (pick < 50) begin
            a = $urandom_range(0, 1023);
            if ($urandom_range(0, 9) == 0) b = $urandom_range(0, a);
            else if ($urandom_range(0, 19) == 0) b = a + $urandom_range(0, 40);
            else b = a + $urandom_range(0, 7);
            if (b > 1023) b = 1023;
            d = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 5);
            if ($urandom_range(0, 29) == 0) d = 16'hFFFF;
            write_slot($urandom_range(0, tas_pkg::NUM_SLOTS - 1), a, b, d, 2'($urandom));
        end else if (pick < 75 || written_list.size() == 0) begin
            write_remap($urandom_range(0, 1023), $urandom);
        end else begin
            lookup(written_list[$urandom_range(0, written_list.size() - 1)]);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        write_remap(0, 0);
        write_remap(1, 1023);
        write_remap(2, 3);
        write_remap(3, 2);
        write_remap(1023, 1023);
        lookup(1);
        write_slot(0, 0, 3, 1, tas_pkg::MODE_PINGPONG);
        write_slot(1, 4, 7, 1, tas_pkg::MODE_RANDOM);
        write_slot(127, 1023, 1023, 1, tas_pkg::MODE_BACKWARD);
        write_slot(5, 8, 2, 2, tas_pkg::MODE_FORWARD);
        write_slot(2, 0, 1023, 0, tas_pkg::MODE_PINGPONG);
        write_slot(3, 0, 3, 16'hFFFF, tas_pkg::MODE_PINGPONG);
        repeat (4) tick();
        lookup(0);
        lookup(1);
        lookup(1023);
        lookup(5);

        for (int n = 0; n < 150; n++) begin
            if (n == 50) hold_rx = 1;
            if (n == 100) begin
                s_valid <= 0;
                while (sb.lookups_due.size() != 0) @(posedge aclk);
            end
            if (n == 128) quiet = 1;
            random_word();
        end
        s_valid <= 0;

        while (sb.lookups_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Covered %0d words (%0d ticks, %0d slot firings), %0d results checked.",
                 sent, ticks, sb.fired, sb.checked);
        $display("Remap entries written: %0d, mismatches: %0d.",
                 written_list.size(), sb.errors);
        if (sb.errors == 0 && sb.lookups_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
